// File: hdl/psf_pkg.sv
// Package for the packet slot FIFO: request and response payload types,
// status and kind codes, fixed field widths. No dependencies.
package psf_pkg;

   localparam int LIMIT_W   = 8;
   localparam int PKT_LEN_W = 5;
   localparam int STATUS_W  = 3;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DATA     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERLONG = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_TOOBIG   = 3'd5;

   localparam logic [LIMIT_W-1:0] READ_LIMIT_RESET = 8'd32;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 out_last;
      logic [STATUS_W-1:0]  status;
      logic [PKT_LEN_W-1:0] packet_length;
   } rsp_type;

endpackage

// File: hdl/psf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module psf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/psf_rsp_queue.sv
// Two-entry response queue that decouples result generation from the
// consumer's ready. Depends on psf_pkg.
module psf_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  psf_pkg::rsp_type  push_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psf_pkg::rsp_type  rsp_data,
   output logic [1:0]        count
);
   import psf_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/packet_slot_fifo_top.sv
// Packet slot FIFO top level: slot byte RAM, slot length RAM, pop sequencer
// and response queue. Depends on psf_pkg, psf_ram and psf_rsp_queue.
//
// A push transfer stores its byte into the tail slot of the byte RAM when
// the ring has room and the slot has space; only the final byte of a
// packet yields a response. A pop transfer on an empty ring answers at
// once. Otherwise the length of the oldest slot is fetched from the length
// RAM through its registered read, then the packet streams out one byte per
// cycle from the byte RAM's read port; the pop holds the request side until
// the packet has streamed out or is dropped as too large. Results pass
// through a two-entry queue so the block keeps working while a finished
// result waits; a stalled consumer pauses the byte stream.
// No clearing pass follows reset: a slot is only read after it was written.
module packet_slot_fifo_top #(
   parameter int SLOTS      = 8,
   parameter int SLOT_BYTES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  psf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output psf_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [psf_pkg::LIMIT_W-1:0]   csr_wdata
);
   import psf_pkg::*;

   localparam int MAX_LEN = SLOT_BYTES - 1;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int USED_W  = $clog2(SLOTS + 1);
   localparam int OFF_W   = $clog2(SLOT_BYTES + 1);
   localparam int LEN_W   = $clog2(SLOT_BYTES);
   localparam int ADDR_W  = $clog2(SLOTS * SLOT_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LEN  = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [OFF_W-1:0]    wo_ff, wo_in;
   logic                blocked_ff, blocked_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_ram_ff, s1_ram_in;
   rsp_type             s1_rsp_ff, s1_rsp_in;

   logic                req_fire;
   logic                out_fire;
   logic                credit;
   logic [1:0]          q_count;
   logic                has_room;
   logic                blocked_now;
   logic [OFF_W-1:0]    wo_inc;
   logic                fits;
   logic                too_big;
   logic                run_last;
   logic                byte_we;
   logic [ADDR_W-1:0]   byte_wr_addr;
   logic [ADDR_W-1:0]   byte_rd_addr;
   logic [7:0]          byte_rdata;
   logic                len_we;
   logic [LEN_W-1:0]    len_rdata;
   rsp_type             q_push_data;

   // A result may enter the pipe only if the queue can still absorb it.
   assign out_fire  = rsp_valid & rsp_ready;
   assign credit    = ((3'(q_count) + 3'(s1_valid_ff)) < 3'd2) | out_fire;
   assign req_ready = (state_ff == ST_IDLE) & credit;
   assign req_fire  = req_valid & req_ready;

   assign has_room    = used_ff < USED_W'(SLOTS);
   assign blocked_now = blocked_ff | ~has_room;
   assign wo_inc      = (wo_ff < OFF_W'(SLOT_BYTES)) ? wo_ff + OFF_W'(1) : wo_ff;
   assign fits        = wo_inc <= OFF_W'(MAX_LEN);

   assign byte_we      = req_fire & (req_data.kind == KIND_PUSH) & has_room
                         & (wo_ff < OFF_W'(MAX_LEN));
   assign byte_wr_addr = ADDR_W'(tail_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wo_ff);
   assign byte_rd_addr = base_ff + ADDR_W'(k_ff);
   assign len_we       = req_fire & (req_data.kind == KIND_PUSH) & req_data.last
                         & ~blocked_now & fits;

   assign too_big  = ((LIMIT_W + 1)'(len_ff) > (LIMIT_W + 1)'(limit_ff))
                     | (len_ff == LEN_W'(0));
   assign run_last = ((LEN_W + 1)'(k_ff) + (LEN_W + 1)'(1)) == (LEN_W + 1)'(len_ff);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      used_in     = used_ff;
      wo_in       = wo_ff;
      blocked_in  = blocked_ff;
      base_in     = base_ff;
      len_in      = len_ff;
      k_in        = k_ff;
      s1_valid_in = 1'b0;
      s1_ram_in   = 1'b0;
      s1_rsp_in   = '0;
      s1_rsp_in.out_last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == KIND_PUSH) begin
                  wo_in      = wo_inc;
                  blocked_in = blocked_now;
                  if (req_data.last) begin
                     s1_valid_in = 1'b1;
                     s1_rsp_in.packet_length = fits ? PKT_LEN_W'(wo_inc) : '0;
                     if (blocked_now) begin
                        s1_rsp_in.status = STATUS_FULL;
                     end else if (!fits) begin
                        s1_rsp_in.status = STATUS_OVERLONG;
                     end else begin
                        s1_rsp_in.status = STATUS_ACCEPT;
                        tail_in = (tail_ff == SLOT_W'(SLOTS - 1)) ? '0 : tail_ff + SLOT_W'(1);
                        used_in = used_ff + USED_W'(1);
                     end
                     wo_in      = '0;
                     blocked_in = 1'b0;
                  end
               end else if (used_ff == '0) begin
                  s1_valid_in      = 1'b1;
                  s1_rsp_in.status = STATUS_EMPTY;
               end else begin
                  // Length RAM reads the head slot this cycle.
                  base_in  = ADDR_W'(head_ff) * ADDR_W'(SLOT_BYTES);
                  head_in  = (head_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_ff + SLOT_W'(1);
                  used_in  = used_ff - USED_W'(1);
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            len_in   = len_rdata;
            k_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (credit) begin
               s1_valid_in             = 1'b1;
               s1_rsp_in.packet_length = PKT_LEN_W'(len_ff);
               if (too_big) begin
                  s1_rsp_in.status = STATUS_TOOBIG;
                  state_in         = ST_IDLE;
               end else begin
                  // Byte k is read now; its data lands with the s1 stage.
                  s1_ram_in          = 1'b1;
                  s1_rsp_in.status   = STATUS_DATA;
                  s1_rsp_in.out_last = run_last;
                  k_in               = k_ff + LEN_W'(1);
                  if (run_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         used_ff     <= '0;
         wo_ff       <= '0;
         blocked_ff  <= 1'b0;
         limit_ff    <= READ_LIMIT_RESET;
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         used_ff     <= used_in;
         wo_ff       <= wo_in;
         blocked_ff  <= blocked_in;
         k_ff        <= k_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      len_ff    <= len_in;
      s1_ram_ff <= s1_ram_in;
      s1_rsp_ff <= s1_rsp_in;
   end

   psf_ram #(
      .WIDTH (8),
      .DEPTH (SLOTS * SLOT_BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_wr_addr),
      .wr_data (req_data.data_byte),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rdata)
   );

   psf_ram #(
      .WIDTH (LEN_W),
      .DEPTH (SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (tail_ff),
      .wr_data (LEN_W'(wo_inc)),
      .rd_addr (head_ff),
      .rd_data (len_rdata)
   );

   always_comb begin
      q_push_data = s1_rsp_ff;
      if (s1_ram_ff) begin
         q_push_data.out_byte = byte_rdata;
      end
   end

   psf_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (q_push_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .count      (q_count)
   );

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(SLOTS))
      else $error("slot count exceeds ring size");

   a_ring_ptrs: assert property (@(posedge clock) disable iff (reset)
      (used_ff == '0 || used_ff == USED_W'(SLOTS)) |-> head_ff == tail_ff)
      else $error("head and tail disagree with slot count");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (3'(q_count) + 3'(s1_valid_ff)) <= 3'd2)
      else $error("response queue overcommitted");

   a_pop_fetch: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.kind == KIND_POP && used_ff != '0) |=> state_ff == ST_LEN)
      else $error("pop of a stored packet did not fetch its length");

   a_run_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && k_ff != '0) |-> k_ff < len_ff)
      else $error("byte index ran past packet length");

endmodule

// File: test/tb_packet_slot_fifo_top.sv
// Self-checking testbench for packet_slot_fifo_top: directed and random push/pop
// traffic against a behavioral slot-ring predictor, with random handshake pacing.
// Depends on psf_pkg and the packet_slot_fifo_top RTL.
`timescale 1ns / 100ps

module tb_packet_slot_fifo_top;
   import psf_pkg::*;

   localparam int SLOTS      = 8;
   localparam int SLOT_BYTES = 32;
   localparam int MAX_PKT    = SLOT_BYTES - 1;
   localparam int PHASE_ITEMS = 48;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type      req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;
   logic         csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   packet_slot_fifo_top #(
      .SLOTS(SLOTS),
      .SLOT_BYTES(SLOT_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // Predicted ring state
   logic [7:0]           ring_bytes [SLOTS*SLOT_BYTES];
   logic [PKT_LEN_W-1:0] ring_len [SLOTS];
   logic [2:0]           head_slot;
   logic [2:0]           tail_slot;
   logic [3:0]           stored_pkts;
   logic [5:0]           fill_offset;
   logic                 fill_blocked;
   logic [LIMIT_W-1:0]   read_limit;
   rsp_type              pending_rsp[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int error_count;
   int items_sent;
   int rsp_count;
   int status_hits [8];

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Sample at the edge, compare a moment later so the prediction made at the
   // same edge is already queued.
   always begin : rsp_check
      rsp_type got;
      rsp_type want;
      logic    took;
      @(posedge clock);
      took = !reset && rsp_valid && rsp_ready;
      got  = rsp_data;
      #1;
      if (took) begin
         rsp_count++;
         status_hits[got.status]++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: byte %0d last %0d status %0d length %0d",
                   got.out_byte, got.out_last, got.status, got.packet_length);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("out_last", want.out_last, got.out_last);
            check_field("status", want.status, got.status);
            check_field("packet_length", want.packet_length, got.packet_length);
         end
      end
   end

   task automatic predict_fifo(input req_type item);
      rsp_type r;
      logic    room;
      int      len;
      int      base;
      r.out_byte = 8'd0;
      r.out_last = 1'b1;
      if (item.kind == KIND_PUSH) begin
         room = (stored_pkts < SLOTS);
         if (!room) fill_blocked = 1'b1;
         if (room && fill_offset < MAX_PKT)
            ring_bytes[tail_slot*SLOT_BYTES + fill_offset] = item.data_byte;
         if (fill_offset < SLOT_BYTES) fill_offset++;
         if (item.last) begin
            r.packet_length = (fill_offset <= MAX_PKT) ? fill_offset[PKT_LEN_W-1:0] : '0;
            if (fill_blocked || !room) begin
               r.status = STATUS_FULL;
            end else if (fill_offset > MAX_PKT) begin
               r.status = STATUS_OVERLONG;
            end else begin
               r.status = STATUS_ACCEPT;
               ring_len[tail_slot] = fill_offset[PKT_LEN_W-1:0];
               tail_slot = (tail_slot == SLOTS-1) ? 3'd0 : tail_slot + 3'd1;
               stored_pkts++;
            end
            fill_offset  = '0;
            fill_blocked = 1'b0;
            pending_rsp.push_back(r);
         end
      end else if (stored_pkts == 0) begin
         r.status        = STATUS_EMPTY;
         r.packet_length = '0;
         pending_rsp.push_back(r);
      end else begin
         len  = ring_len[head_slot];
         base = head_slot * SLOT_BYTES;
         head_slot = (head_slot == SLOTS-1) ? 3'd0 : head_slot + 3'd1;
         stored_pkts--;
         r.packet_length = len[PKT_LEN_W-1:0];
         if (len > read_limit || len == 0) begin
            r.status = STATUS_TOOBIG;
            pending_rsp.push_back(r);
         end else begin
            r.status = STATUS_DATA;
            for (int k = 0; k < len; k++) begin
               r.out_byte = ring_bytes[base + k];
               r.out_last = (k == len - 1);
               pending_rsp.push_back(r);
            end
         end
      end
   endtask

   // Called and left at a falling edge; valid stays high for the next transfer.
   task automatic send_item(input logic kind, input logic [7:0] data_byte,
                            input logic last);
      req_type item;
      item.kind      = kind;
      item.data_byte = data_byte;
      item.last      = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      predict_fifo(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pop_packet();
      send_item(KIND_POP, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // Push a packet of random bytes; optionally slip pops in between its bytes.
   task automatic push_packet(input int len, input int pop_in_pct);
      for (int i = 0; i < len; i++) begin
         send_item(KIND_PUSH, 8'($urandom_range(255)), i == len - 1);
         if (i < len - 1 && $urandom_range(99) < pop_in_pct) pop_packet();
      end
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_read_limit(input logic [LIMIT_W-1:0] value);
      drain_results();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we     = 1'b0;
      read_limit = value;
   endtask

   task automatic test_empty_and_single();
      pop_packet();
      send_item(KIND_POP, 8'h00, 1'b0);
      send_item(KIND_PUSH, 8'h00, 1'b1);
      send_item(KIND_PUSH, 8'hFF, 1'b1);
      send_item(KIND_POP, 8'hFF, 1'b1);
      pop_packet();
      pop_packet();
   endtask

   task automatic test_ring_full();
      for (int s = 0; s < SLOTS; s++) push_packet((s == 0) ? 3 : 1, 0);
      push_packet(2, 0);
      // Byte arrives while full, a pop frees a slot, the packet still fails
      send_item(KIND_PUSH, 8'h5A, 1'b0);
      pop_packet();
      send_item(KIND_PUSH, 8'hA5, 1'b1);
      push_packet(1, 0);
      for (int s = 0; s <= SLOTS; s++) pop_packet();
   endtask

   task automatic test_long_packets();
      write_read_limit(8'd255);
      push_packet(MAX_PKT, 0);
      push_packet(SLOT_BYTES, 0);
      push_packet(SLOT_BYTES + 8, 0);
      pop_packet();
      // Full and overlong together
      for (int s = 0; s < SLOTS; s++) push_packet(1, 0);
      push_packet(SLOT_BYTES + 1, 0);
      for (int s = 0; s < SLOTS; s++) pop_packet();
   endtask

   task automatic test_read_limit_extremes();
      write_read_limit(8'd0);
      push_packet(1, 0);
      pop_packet();
      write_read_limit(8'd30);
      push_packet(MAX_PKT, 0);
      push_packet(30, 0);
      pop_packet();
      pop_packet();
      write_read_limit(READ_LIMIT_RESET);
   endtask

   task automatic test_random_traffic();
      int start;
      int len;
      int pop_pct;
      int pick;
      bit paused;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
         endcase
         case (phase)
            0: write_read_limit(8'd255);
            1: write_read_limit(8'd3);
            2: write_read_limit(8'd31);
            default: write_read_limit(8'($urandom_range(1, 40)));
         endcase
         pop_pct = (phase % 2) ? 55 : 35;
         start   = items_sent;
         paused  = 0;
         while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(99) < pop_pct) begin
               pop_packet();
            end else begin
               pick = $urandom_range(99);
               if (pick < 70)      len = $urandom_range(1, 6);
               else if (pick < 93) len = $urandom_range(7, MAX_PKT);
               else                len = $urandom_range(SLOT_BYTES, SLOT_BYTES + 4);
               push_packet(len, 6);
            end
            // Hold off until the block has answered everything
            if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1;
            end
         end
      end
   endtask

   initial begin
      #(12 * 1_000_000);
      $display("packet_slot_fifo_top test failed");
      $finish;
   end

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      head_slot    = '0;
      tail_slot    = '0;
      stored_pkts  = '0;
      fill_offset  = '0;
      fill_blocked = 1'b0;
      read_limit   = READ_LIMIT_RESET;
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      error_count = 0;
      items_sent  = 0;
      rsp_count   = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_single();
      test_ring_full();
      test_long_packets();
      test_read_limit_extremes();
      test_random_traffic();
      drain_results();
      repeat (40) @(negedge clock);

      $display("Sent %0d requests, checked %0d responses over four pacing modes and",
               items_sent, rsp_count);
      $display("read limits 0..255: data %0d, accepted %0d, full %0d, overlong %0d,",
               status_hits[STATUS_DATA], status_hits[STATUS_ACCEPT],
               status_hits[STATUS_FULL], status_hits[STATUS_OVERLONG]);
      $display("empty %0d, dropped %0d",
               status_hits[STATUS_EMPTY], status_hits[STATUS_TOOBIG]);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("packet_slot_fifo_top test passed");
      end else begin
         if (pending_rsp.size() != 0)
            $error("%0d expected responses never arrived", pending_rsp.size());
         $display("packet_slot_fifo_top test failed");
      end
      $finish;
   end

endmodule
